FILE: rtl/core/cba_pkg.sv
// Shared types and constants of the chunked bump allocator.
// No dependencies; used by cba_round_unit and chunked_bump_allocator.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

  // Field widths
  localparam int SIZE_W    = 24;
  localparam int ALIGN_W   = 13;
  localparam int RSIZE_W   = SIZE_W + 1;   // a rounded 24-bit value
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_OUT_W = 4;

  // Remainder unit: dividend bits retired per cycle
  localparam int RND_DIGIT = 2;
  localparam int RND_STEPS = SIZE_W / RND_DIGIT;

  localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WASTE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT      = 3'd4;

  // Register reset values
  localparam logic [SIZE_W-1:0]  INITIAL_SIZE_RST   = 24'd4096;
  localparam logic [SIZE_W-1:0]  INCREMENT_SIZE_RST = 24'd4096;
  localparam logic [SIZE_W-1:0]  MAX_TOTAL_RST      = 24'd0;
  localparam logic [SIZE_W-1:0]  WASTE_LIMIT_RST    = 24'd0;
  localparam logic [ALIGN_W-1:0] ALIGNMENT_RST      = 13'd8;

  typedef enum logic [1:0] {
    ST_STORED     = 2'd0,
    ST_OVER_LIMIT = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSIZE,
    S_LIMIT,
    S_WASTE,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_FIT,
    S_BASE,
    S_REPLY
  } state_t;

  // Status of the shared rounding unit
  typedef struct packed {
    logic busy;
    logic done;
  } rnd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/cba_round_unit.sv
// Shared round-up-to-alignment unit: remainder by shift and subtract.
// Depends on cba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cba_round_unit
  import cba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SIZE_W-1:0]  value,
  input  logic [ALIGN_W-1:0] align,
  output rnd_stat_t          stat,
  output logic [RSIZE_W-1:0] result
);

  localparam int CNT_W = $clog2(RND_STEPS + 1);

  logic               busy_r, busy_nxt;
  logic               fin_r, fin_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]  shf_r, shf_nxt;
  logic [SIZE_W-1:0]  orig_r, orig_nxt;
  logic [ALIGN_W-1:0] rem_r, rem_nxt;
  logic [RSIZE_W-1:0] res_r, res_nxt;
  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W-1:0] part;

  // One digit of restoring remainder: RND_DIGIT dependent compare-subtracts
  always_comb begin
    part  = rem_r;
    trial = '0;
    for (int i = 0; i < RND_DIGIT; i++) begin
      trial = {part, shf_r[SIZE_W-1-i]};
      if (trial >= {1'b0, align}) begin
        trial = trial - {1'b0, align};
      end
      part = trial[ALIGN_W-1:0];
    end
  end

  // Sequencing: load, RND_STEPS steps, final add
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    shf_nxt  = shf_r;
    orig_nxt = orig_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    if (start && !busy_r && !fin_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      shf_nxt  = value;
      orig_nxt = value;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = part;
      shf_nxt = shf_r << RND_DIGIT;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(RND_STEPS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      if (rem_r == '0) begin
        res_nxt = {1'b0, orig_r};
      end else begin
        res_nxt = {1'b0, orig_r} + {{(RSIZE_W-ALIGN_W){1'b0}}, align - rem_r};
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    shf_r  <= shf_nxt;
    orig_r <= orig_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;
  assign result    = res_r;

endmodule

`default_nettype wire

FILE: rtl/core/chunked_bump_allocator.sv
// Chunked bump allocator top level: sequencer, department tables, result register.
// Depends on cba_pkg and cba_round_unit.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_ready   | in_request_size
//  out     | out_valid / out_ready | out_status, out_department_index,
//          |                       | out_byte_offset, out_created_department
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time. Every round-up goes through the shared remainder unit,
// 2 dividend bits per cycle. A request rounds its size, the total limit and the
// waste limit, checks the total limit, then visits departments (scan, table read,
// rounding of the fill and fit test for each). Creating a department rounds its
// base size; a full table skips this. The reply step hands over the result.
// Synchronous active-low reset; no clearing pass (tables are read only below
// the department count). A new request is taken while an old result still
// waits; the new one holds in the reply step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module chunked_bump_allocator
  import cba_pkg::*;
#(
  parameter int MAX_DEPARTMENTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SIZE_W-1:0]    in_request_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [IDX_OUT_W-1:0] out_department_index,
  output logic [SIZE_W-1:0]    out_byte_offset,
  output logic                 out_created_department,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(MAX_DEPARTMENTS + 1);
  localparam int ADDR_W = (MAX_DEPARTMENTS > 1) ? $clog2(MAX_DEPARTMENTS) : 1;

  // Configuration
  logic [SIZE_W-1:0]  initial_size_r, increment_size_r, max_total_r, waste_limit_r;
  logic [ALIGN_W-1:0] alignment_r;
  logic [ALIGN_W-1:0] align_eff;

  // Control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   dept_count_r, dept_count_nxt;
  logic [CNT_W-1:0]   first_open_r, first_open_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [TOTAL_W-1:0] total_used_r, total_used_nxt;
  logic               out_valid_r;

  // Per-request payload
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [RSIZE_W-1:0]   rsize_r, rsize_nxt;
  logic [RSIZE_W-1:0]   limit_r, limit_nxt;
  logic [RSIZE_W-1:0]   waste_r, waste_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [IDX_OUT_W-1:0] res_idx_r, res_idx_nxt;
  logic [SIZE_W-1:0]    res_off_r, res_off_nxt;
  logic                 res_made_r, res_made_nxt;
  status_t              out_status_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [SIZE_W-1:0]    out_off_r;
  logic                 out_made_r;
  logic                 out_load;

  // Department tables
  logic [SIZE_W-1:0] cap_mem  [MAX_DEPARTMENTS];
  logic [SIZE_W-1:0] fill_mem [MAX_DEPARTMENTS];
  logic [SIZE_W-1:0] cap_q, fill_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              cap_we, fill_we;
  logic [SIZE_W-1:0] wr_cap, wr_fill;

  // Rounding unit hookup
  logic               rnd_start;
  logic [SIZE_W-1:0]  rnd_value;
  rnd_stat_t          rnd_stat;
  logic [RSIZE_W-1:0] rnd_result;

  // Datapath terms
  logic [RSIZE_W:0]   fit_end;
  logic               fits;
  logic [SIZE_W-1:0]  slack;
  logic               is_full;
  logic [TOTAL_W:0]   used_plus;
  logic               over_limit;
  logic [TOTAL_W:0]   used_sum;
  logic [TOTAL_W-1:0] used_sat;
  logic [RSIZE_W-1:0] new_cap;
  logic [SIZE_W-1:0]  new_cap_sat;

  assign align_eff = (alignment_r == '0) ? ALIGN_W'(1) : alignment_r;

  cba_round_unit u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rnd_start),
    .value  (rnd_value),
    .align  (align_eff),
    .stat   (rnd_stat),
    .result (rnd_result)
  );

  // Fit test at the aligned fill, full test on free space
  assign fit_end = {1'b0, rnd_result} + {2'b00, size_r};
  assign fits    = (fit_end <= {2'b00, cap_q});
  assign slack   = cap_q - fill_q;
  assign is_full = ({1'b0, slack} <= waste_r);

  // Total limit and saturating usage counter
  assign used_plus  = {1'b0, total_used_r} + (TOTAL_W+1)'(rsize_r);
  assign over_limit = (limit_r != '0) && (used_plus > (TOTAL_W+1)'(limit_r));
  assign used_sum   = {1'b0, total_used_r} + (TOTAL_W+1)'(size_r);
  assign used_sat   = used_sum[TOTAL_W] ? '1 : used_sum[TOTAL_W-1:0];

  // New department capacity: at least the rounded request, saturated
  assign new_cap     = (rnd_result > rsize_r) ? rnd_result : rsize_r;
  assign new_cap_sat = new_cap[SIZE_W] ? SIZE_TOP : new_cap[SIZE_W-1:0];

  assign rd_addr = scan_idx_r[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    dept_count_nxt = dept_count_r;
    first_open_nxt = first_open_r;
    scan_idx_nxt   = scan_idx_r;
    total_used_nxt = total_used_r;
    size_nxt       = size_r;
    rsize_nxt      = rsize_r;
    limit_nxt      = limit_r;
    waste_nxt      = waste_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_off_nxt    = res_off_r;
    res_made_nxt   = res_made_r;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    rnd_start      = 1'b0;
    rnd_value      = size_r;
    cap_we         = 1'b0;
    fill_we        = 1'b0;
    wr_addr        = scan_idx_r[ADDR_W-1:0];
    wr_cap         = new_cap_sat;
    wr_fill        = fit_end[SIZE_W-1:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          size_nxt  = in_request_size;
          rnd_start = 1'b1;
          rnd_value = in_request_size;
          state_nxt = S_RSIZE;
        end
      end
      S_RSIZE: begin
        if (rnd_stat.done) begin
          rsize_nxt = rnd_result;
          rnd_start = 1'b1;
          rnd_value = max_total_r;
          state_nxt = S_LIMIT;
        end
      end
      S_LIMIT: begin
        if (rnd_stat.done) begin
          limit_nxt = rnd_result;
          rnd_start = 1'b1;
          rnd_value = waste_limit_r;
          state_nxt = S_WASTE;
        end
      end
      S_WASTE: begin
        if (rnd_stat.done) begin
          waste_nxt = rnd_result;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (over_limit) begin
          res_status_nxt = ST_OVER_LIMIT;
          res_idx_nxt    = '0;
          res_off_nxt    = '0;
          res_made_nxt   = 1'b0;
          state_nxt      = S_REPLY;
        end else begin
          scan_idx_nxt = first_open_r;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_r < dept_count_r) begin
          state_nxt = S_READ;
        end else if (dept_count_r == CNT_W'(MAX_DEPARTMENTS)) begin
          res_status_nxt = ST_TABLE_FULL;
          res_idx_nxt    = '0;
          res_off_nxt    = '0;
          res_made_nxt   = 1'b0;
          state_nxt      = S_REPLY;
        end else begin
          rnd_start = 1'b1;
          rnd_value = (dept_count_r == '0) ? initial_size_r : increment_size_r;
          state_nxt = S_BASE;
        end
      end
      S_READ: begin
        // table read data is valid now
        rnd_start = 1'b1;
        rnd_value = fill_q;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        if (rnd_stat.done) begin
          if (fits) begin
            fill_we        = 1'b1;
            total_used_nxt = used_sat;
            res_status_nxt = ST_STORED;
            res_idx_nxt    = IDX_OUT_W'(scan_idx_r);
            res_off_nxt    = rnd_result[SIZE_W-1:0];
            res_made_nxt   = 1'b0;
            state_nxt      = S_REPLY;
          end else begin
            if (is_full && (scan_idx_r == first_open_r)) begin
              first_open_nxt = first_open_r + 1'b1;
            end
            scan_idx_nxt = scan_idx_r + 1'b1;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_BASE: begin
        if (rnd_stat.done) begin
          cap_we         = 1'b1;
          fill_we        = 1'b1;
          wr_addr        = dept_count_r[ADDR_W-1:0];
          wr_fill        = size_r;
          dept_count_nxt = dept_count_r + 1'b1;
          total_used_nxt = used_sat;
          res_status_nxt = ST_STORED;
          res_idx_nxt    = IDX_OUT_W'(dept_count_r);
          res_off_nxt    = '0;
          res_made_nxt   = 1'b1;
          state_nxt      = S_REPLY;
        end
      end
      S_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dept_count_r <= '0;
      first_open_r <= '0;
      scan_idx_r   <= '0;
      total_used_r <= '0;
    end else begin
      state_r      <= state_nxt;
      dept_count_r <= dept_count_nxt;
      first_open_r <= first_open_nxt;
      scan_idx_r   <= scan_idx_nxt;
      total_used_r <= total_used_nxt;
    end
  end

  // Request payload registers
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    rsize_r      <= rsize_nxt;
    limit_r      <= limit_nxt;
    waste_r      <= waste_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_off_r    <= res_off_nxt;
    res_made_r   <= res_made_nxt;
  end

  // Department tables, registered read
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[wr_addr] <= wr_cap;
    end
    if (fill_we) begin
      fill_mem[wr_addr] <= wr_fill;
    end
    cap_q  <= cap_mem[rd_addr];
    fill_q <= fill_mem[rd_addr];
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_size_r   <= INITIAL_SIZE_RST;
      increment_size_r <= INCREMENT_SIZE_RST;
      max_total_r      <= MAX_TOTAL_RST;
      waste_limit_r    <= WASTE_LIMIT_RST;
      alignment_r      <= ALIGNMENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INITIAL_SIZE:   initial_size_r   <= cfg_data;
        CFG_INCREMENT_SIZE: increment_size_r <= cfg_data;
        CFG_MAX_TOTAL:      max_total_r      <= cfg_data;
        CFG_WASTE_LIMIT:    waste_limit_r    <= cfg_data;
        CFG_ALIGNMENT:      alignment_r      <= cfg_data[ALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_off_r    <= res_off_r;
      out_made_r   <= res_made_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_department_index   = out_idx_r;
  assign out_byte_offset        = out_off_r;
  assign out_created_department = out_made_r;

  // Checks
  a_first_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_open_r <= dept_count_r)
    else $error("first open department beyond department count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dept_count_r <= CNT_W'(MAX_DEPARTMENTS))
    else $error("department count beyond table size");

  a_fit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_we && !cap_we) |-> (scan_idx_r < dept_count_r))
    else $error("fill update to a department that does not exist");

  a_round_free: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_start |-> !rnd_stat.busy)
    else $error("rounding unit started while busy");

  a_create_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cap_we |=> (dept_count_r == $past(dept_count_r) + 1'b1))
    else $error("department created without count update");

endmodule

`default_nettype wire
